// File: hdl/toroidal_life_generation_macros.svh
// Assertion helpers for the top-level block, which checks itself.
`ifndef TOROIDAL_LIFE_GENERATION_MACROS_SVH
`define TOROIDAL_LIFE_GENERATION_MACROS_SVH

// Check on every clock edge outside reset.
`define TLG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define TLG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/tlg_pkg.sv
package tlg_pkg;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 32;

  localparam int MODE_W      = 2;
  localparam int COL_W       = 6;
  localparam int ROW_FIELD_W = 5;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 8;

  localparam int NEIGH_W = 4;
  localparam logic [NEIGH_W-1:0] NEIGH_BIRTH = 4'd3;
  localparam logic [NEIGH_W-1:0] NEIGH_KEEP  = 4'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2
  } mode_t;

endpackage

// File: hdl/tlg_row_mem.sv
module tlg_row_mem #(
  parameter int DEPTH = tlg_pkg::GRID_HEIGHT_DEF,
  parameter int ROW_W = tlg_pkg::GRID_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ROW_W-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ROW_W-1:0]         rd_data
);

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/tlg_row_rule.sv
module tlg_row_rule #(
  parameter int ROW_W = tlg_pkg::GRID_WIDTH_DEF
) (
  input  logic [ROW_W-1:0] up,
  input  logic [ROW_W-1:0] mid,
  input  logic [ROW_W-1:0] dn,
  output logic [ROW_W-1:0] nxt
);

  localparam int NW = tlg_pkg::NEIGH_W;

  for (genvar c = 0; c < ROW_W; c++) begin : g_col
    localparam int LF = (c + ROW_W - 1) % ROW_W;
    localparam int RT = (c + 1) % ROW_W;
    logic [NW-1:0] n;

    assign n = NW'(up[LF]) + NW'(up[c]) + NW'(up[RT])
             + NW'(mid[LF]) + NW'(mid[RT])
             + NW'(dn[LF]) + NW'(dn[c]) + NW'(dn[RT]);
    assign nxt[c] = (n == tlg_pkg::NEIGH_BIRTH) || ((n == tlg_pkg::NEIGH_KEEP) && mid[c]);
  end

endmodule

// File: hdl/toroidal_life_generation.sv
// Channel   Dir  Bits  Contents
// s_axis    in   16    request: mode, col, row, alive
// m_axis    out  8     result: cell_alive, op_done
//
// Cell read or write inside the grid: access state, then finish loads the result register.
// Generation: rows go through the rule in the generation state, one row per cycle,
// bounded by the single read port of the row memory; finish then loads the result.
// After reset every row of the memory is cleared; no request is taken meanwhile.
// A new request is taken while a result waits in the output register.
`include "toroidal_life_generation_macros.svh"

module toroidal_life_generation #(
  parameter int GRID_WIDTH  = tlg_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = tlg_pkg::GRID_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [1:0] mode, [7:2] col, [12:8] row, [13] alive
  input  logic [tlg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] cell_alive, [1] op_done
  output logic [tlg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int AW = $clog2(GRID_HEIGHT);
  localparam int CW = $clog2(GRID_WIDTH);
  localparam int GW = $clog2(GRID_HEIGHT + 3);
  localparam logic [AW-1:0] LAST_ROW      = AW'(GRID_HEIGHT - 1);
  localparam logic [GW-1:0] STEP_SAVE     = GW'(2);
  localparam logic [GW-1:0] STEP_WR_FIRST = GW'(3);
  localparam logic [GW-1:0] STEP_RD_LAST  = GW'(GRID_HEIGHT);
  localparam logic [GW-1:0] STEP_LAST     = GW'(GRID_HEIGHT + 2);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_GEN,
    ST_FINISH
  } state_t;

  state_t st;

  logic [tlg_pkg::MODE_W-1:0]      in_mode;
  logic [tlg_pkg::COL_W-1:0]       in_col;
  logic [tlg_pkg::ROW_FIELD_W-1:0] in_row;
  logic                            in_alive;
  logic                            in_inside;
  logic                            s_fire;

  logic [CW-1:0]         req_col;
  logic [AW-1:0]         req_row;
  logic                  req_alive;
  logic                  req_write;
  logic                  res_cell;
  logic                  res_done;
  logic [GW-1:0]         gen_step;
  logic [AW-1:0]         wr_row;
  logic [GRID_WIDTH-1:0] w_a;
  logic [GRID_WIDTH-1:0] w_b;
  logic [GRID_WIDTH-1:0] row0;

  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [GRID_WIDTH-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [GRID_WIDTH-1:0] rd_data;
  logic [GRID_WIDTH-1:0] rule_dn;
  logic [GRID_WIDTH-1:0] rule_out;
  logic [GRID_WIDTH-1:0] bit_mask;
  logic [GRID_WIDTH-1:0] bit_set;

  assign in_mode   = s_axis_tdata[1:0];
  assign in_col    = s_axis_tdata[7:2];
  assign in_row    = s_axis_tdata[12:8];
  assign in_alive  = s_axis_tdata[13];
  assign in_inside = (int'(in_col) < GRID_WIDTH) && (int'(in_row) < GRID_HEIGHT);

  assign s_axis_tready = (st == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign rule_dn  = (gen_step == STEP_LAST) ? row0 : rd_data;
  assign bit_mask = GRID_WIDTH'(1) << req_col;
  assign bit_set  = GRID_WIDTH'(req_alive) << req_col;

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(in_row);
    mem_wr_en   = 1'b0;
    mem_wr_addr = wr_row;
    mem_wr_data = rule_out;
    unique case (st)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = '0;
      end
      ST_IDLE: begin
        mem_rd_en = s_fire && in_inside &&
                    ((in_mode == tlg_pkg::MODE_WRITE) || (in_mode == tlg_pkg::MODE_READ));
      end
      ST_ACCESS: begin
        mem_wr_en   = req_write;
        mem_wr_addr = req_row;
        mem_wr_data = (rd_data & ~bit_mask) | bit_set;
      end
      ST_GEN: begin
        mem_rd_en   = (gen_step <= STEP_RD_LAST);
        mem_rd_addr = (gen_step == '0) ? LAST_ROW : AW'(gen_step - GW'(1));
        mem_wr_en   = (gen_step >= STEP_WR_FIRST);
      end
      default: begin
      end
    endcase
  end

  tlg_row_mem #(
    .DEPTH (GRID_HEIGHT),
    .ROW_W (GRID_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_data)
  );

  tlg_row_rule #(
    .ROW_W (GRID_WIDTH)
  ) u_rule (
    .up  (w_a),
    .mid (w_b),
    .dn  (rule_dn),
    .nxt (rule_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_CLEAR;
      wr_row        <= '0;
      gen_step      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (st != ST_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (st)
        ST_CLEAR: begin
          if (wr_row == LAST_ROW) begin
            wr_row <= '0;
            st     <= ST_IDLE;
          end else begin
            wr_row <= wr_row + AW'(1);
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            req_col   <= CW'(in_col);
            req_row   <= AW'(in_row);
            req_alive <= in_alive;
            req_write <= (in_mode == tlg_pkg::MODE_WRITE);
            res_cell  <= 1'b0;
            gen_step  <= '0;
            wr_row    <= '0;
            unique case (tlg_pkg::mode_t'(in_mode))
              tlg_pkg::MODE_WRITE,
              tlg_pkg::MODE_READ: begin
                res_done <= 1'b1;
                st       <= in_inside ? ST_ACCESS : ST_FINISH;
              end
              tlg_pkg::MODE_STEP: begin
                res_done <= 1'b1;
                st       <= ST_GEN;
              end
              default: begin
                res_done <= 1'b0;
                st       <= ST_FINISH;
              end
            endcase
          end
        end
        ST_ACCESS: begin
          res_cell <= req_write ? req_alive : rd_data[req_col];
          st       <= ST_FINISH;
        end
        ST_GEN: begin
          gen_step <= gen_step + GW'(1);
          w_a      <= w_b;
          w_b      <= rd_data;
          if (gen_step == STEP_SAVE) begin
            row0 <= rd_data;
          end
          if (gen_step >= STEP_WR_FIRST) begin
            wr_row <= wr_row + AW'(1);
          end
          if (gen_step == STEP_LAST) begin
            st <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'b0, res_done, res_cell};
            st            <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  `TLG_ASSERT(a_no_port_clash, (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr), "row memory read and write hit the same row")
  `TLG_ASSERT(a_wr_row_trails, (st == ST_GEN && gen_step >= STEP_WR_FIRST) |-> (wr_row == AW'(gen_step - STEP_WR_FIRST)), "generation write row out of step with reads")
  `TLG_ASSERT(a_result_from_finish, $rose(m_axis_tvalid) |-> ($past(st) == ST_FINISH), "result raised outside finish")
  `TLG_ASSERT_ALWAYS(a_reset_clears, rst |=> (st == ST_CLEAR && !m_axis_tvalid), "reset did not start the clearing pass")

endmodule
